@@ sv/sgcd_pkg.sv @@
// sgcd_pkg: shared types, control word layout and microcode program for
// the signed GCD unit. No dependencies.
package sgcd_pkg;

    localparam int PORT_WIDTH = 64;
    localparam int PC_WIDTH   = 4;

    typedef logic [PC_WIDTH-1:0] pc_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_HALVE_BOTH,
        OP_HALVE_A,
        OP_HALVE_B,
        OP_SUB_SWAP,
        OP_MOVE_B,
        OP_FINISH
    } op_t;

    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_A_ZERO,
        CND_B_ZERO,
        CND_EITHER_ODD,
        CND_A_ODD,
        CND_B_ODD,
        CND_B_NONZERO,
        CND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    // flags from the datapath and the ports, sampled by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic a_zero;
        logic b_zero;
        logic a_odd;
        logic b_odd;
    } status_t;

    localparam pc_t STEP_IDLE       = 4'd0;
    localparam pc_t STEP_CHK_A      = 4'd1;
    localparam pc_t STEP_CHK_B      = 4'd2;
    localparam pc_t STEP_TEST_TWOS  = 4'd3;
    localparam pc_t STEP_HALVE_BOTH = 4'd4;
    localparam pc_t STEP_TEST_A     = 4'd5;
    localparam pc_t STEP_HALVE_A    = 4'd6;
    localparam pc_t STEP_TEST_B     = 4'd7;
    localparam pc_t STEP_HALVE_B    = 4'd8;
    localparam pc_t STEP_SUB        = 4'd9;
    localparam pc_t STEP_LOOP       = 4'd10;
    localparam pc_t STEP_FINISH     = 4'd11;
    localparam pc_t STEP_HOLD       = 4'd12;
    localparam pc_t STEP_TAKE_B     = 4'd13;

    // binary GCD program; a jump is taken when cond holds, else pc + 1
    function automatic ctrl_t ucode_word(input pc_t pc);
        ctrl_t w;
        case (pc)
            STEP_IDLE:       w = '{OP_LOAD,       CND_NO_INPUT,   STEP_IDLE};
            STEP_CHK_A:      w = '{OP_NOP,        CND_A_ZERO,     STEP_TAKE_B};
            STEP_CHK_B:      w = '{OP_NOP,        CND_B_ZERO,     STEP_FINISH};
            STEP_TEST_TWOS:  w = '{OP_NOP,        CND_EITHER_ODD, STEP_TEST_A};
            STEP_HALVE_BOTH: w = '{OP_HALVE_BOTH, CND_ALWAYS,     STEP_TEST_TWOS};
            STEP_TEST_A:     w = '{OP_NOP,        CND_A_ODD,      STEP_TEST_B};
            STEP_HALVE_A:    w = '{OP_HALVE_A,    CND_ALWAYS,     STEP_TEST_A};
            STEP_TEST_B:     w = '{OP_NOP,        CND_B_ODD,      STEP_SUB};
            STEP_HALVE_B:    w = '{OP_HALVE_B,    CND_ALWAYS,     STEP_TEST_B};
            STEP_SUB:        w = '{OP_SUB_SWAP,   CND_NEVER,      STEP_IDLE};
            STEP_LOOP:       w = '{OP_NOP,        CND_B_NONZERO,  STEP_TEST_B};
            STEP_FINISH:     w = '{OP_FINISH,     CND_OUT_FREE,   STEP_IDLE};
            STEP_HOLD:       w = '{OP_NOP,        CND_ALWAYS,     STEP_FINISH};
            STEP_TAKE_B:     w = '{OP_MOVE_B,     CND_ALWAYS,     STEP_FINISH};
            default:         w = '{OP_NOP,        CND_ALWAYS,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ sv/sgcd_seq.sv @@
// sgcd_seq: step counter and jump logic for the GCD microcode.
// Depends on sgcd_pkg (control word, status flags, program table).
module sgcd_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  sgcd_pkg::status_t  status,
    output sgcd_pkg::ctrl_t    ctrl
);

    sgcd_pkg::pc_t pc_reg;
    sgcd_pkg::pc_t pc_next;
    logic          jump;

    assign ctrl = sgcd_pkg::ucode_word(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            sgcd_pkg::CND_NEVER:      jump = 1'b0;
            sgcd_pkg::CND_ALWAYS:     jump = 1'b1;
            sgcd_pkg::CND_NO_INPUT:   jump = !status.in_valid;
            sgcd_pkg::CND_A_ZERO:     jump = status.a_zero;
            sgcd_pkg::CND_B_ZERO:     jump = status.b_zero;
            sgcd_pkg::CND_EITHER_ODD: jump = status.a_odd || status.b_odd;
            sgcd_pkg::CND_A_ODD:      jump = status.a_odd;
            sgcd_pkg::CND_B_ODD:      jump = status.b_odd;
            sgcd_pkg::CND_B_NONZERO:  jump = !status.b_zero;
            sgcd_pkg::CND_OUT_FREE:   jump = status.out_free;
            default:                  jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (jump)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= sgcd_pkg::STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

@@ sv/sgcd_dp.sv @@
// sgcd_dp: operand registers, subtract and shift logic for binary GCD.
// Depends on sgcd_pkg (op codes, status flags).
module sgcd_dp #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  sgcd_pkg::op_t         op,
    input  logic                  load_en,
    input  logic [DATA_WIDTH-1:0] first_raw,
    input  logic [DATA_WIDTH-1:0] second_raw,
    output logic                  a_zero,
    output logic                  b_zero,
    output logic                  a_odd,
    output logic                  b_odd,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int KW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [DATA_WIDTH-1:0] first_mag, second_mag;
    logic                  a_greater;
    logic [DATA_WIDTH-1:0] diff;

    // most negative value negates to itself, read unsigned as 2^(W-1)
    assign first_mag  = first_raw[DATA_WIDTH-1]  ? (~first_raw + 1'b1)  : first_raw;
    assign second_mag = second_raw[DATA_WIDTH-1] ? (~second_raw + 1'b1) : second_raw;

    assign a_greater = a_reg > b_reg;
    assign diff      = a_greater ? (a_reg - b_reg) : (b_reg - a_reg);

    assign a_zero = (a_reg == '0);
    assign b_zero = (b_reg == '0);
    assign a_odd  = a_reg[0];
    assign b_odd  = b_reg[0];
    assign result = a_reg << k_reg;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        case (op)
            sgcd_pkg::OP_LOAD:
            begin
                if (load_en)
                begin
                    a_next = first_mag;
                    b_next = second_mag;
                    k_next = '0;
                end
            end
            sgcd_pkg::OP_HALVE_BOTH:
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            sgcd_pkg::OP_HALVE_A:    a_next = a_reg >> 1;
            sgcd_pkg::OP_HALVE_B:    b_next = b_reg >> 1;
            sgcd_pkg::OP_SUB_SWAP:
            begin
                // keep the smaller odd value in a, difference goes to b
                if (a_greater)
                    a_next = b_reg;
                b_next = diff;
            end
            sgcd_pkg::OP_MOVE_B:     a_next = b_reg;
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

endmodule

@@ sv/signed_gcd_unit.sv @@
// signed_gcd_unit: GCD of two signed operands by microcoded binary GCD.
// A zero operand goes straight to the finish step, skipping halving and subtraction.
// Otherwise the unit loops over halving and subtract steps, and every subtract
// pass strips at least one bit.
// One transaction is in work at a time; the next can be taken in the cycle after
// the result is registered. Reset (rst_n, async) clears the step counter and output valid.
module signed_gcd_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sgcd_pkg::PORT_WIDTH-1:0] first_value,
    input  logic [sgcd_pkg::PORT_WIDTH-1:0] second_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sgcd_pkg::PORT_WIDTH-1:0] divisor
);

    sgcd_pkg::ctrl_t   ctrl;
    sgcd_pkg::status_t status;
    logic [DATA_WIDTH-1:0]            result;
    logic                             a_zero, b_zero, a_odd, b_odd;
    logic                             out_valid_reg, out_valid_next;
    logic [sgcd_pkg::PORT_WIDTH-1:0]  divisor_reg, divisor_next;
    logic                             out_free;
    logic                             finish_load;

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (ctrl.op == sgcd_pkg::OP_LOAD);
    assign finish_load = (ctrl.op == sgcd_pkg::OP_FINISH) && out_free;

    assign status = '{in_valid: in_valid, out_free: out_free, a_zero: a_zero,
                      b_zero: b_zero, a_odd: a_odd, b_odd: b_odd};

    sgcd_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    sgcd_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .op         (ctrl.op),
        .load_en    (in_valid),
        .first_raw  (first_value[DATA_WIDTH-1:0]),
        .second_raw (second_value[DATA_WIDTH-1:0]),
        .a_zero     (a_zero),
        .b_zero     (b_zero),
        .a_odd      (a_odd),
        .b_odd      (b_odd),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        divisor_next   = divisor_reg;
        if (finish_load)
        begin
            out_valid_next = 1'b1;
            divisor_next   = sgcd_pkg::PORT_WIDTH'(result);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
    end

    assign out_valid = out_valid_reg;
    assign divisor   = divisor_reg;

    // no second transaction is taken right after one is accepted
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous transaction in work");

    // a result appears only from the finish step
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.op == sgcd_pkg::OP_FINISH))
        else $error("output valid raised outside finish step");

    // subtract step sees two odd operands
    a_sub_both_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == sgcd_pkg::OP_SUB_SWAP) |-> (a_odd && b_odd))
        else $error("subtract step with an even operand");

endmodule

@@ bench/testbench.sv @@
// testbench: randomized valid/ready check of signed_gcd_unit against a
// built-in Euclidean GCD predictor kept in a small scoreboard class.
// Depends on sgcd_pkg and signed_gcd_unit.
module testbench;

    localparam int OPW        = sgcd_pkg::PORT_WIDTH;
    localparam int N_RANDOM   = 1400;
    localparam int N_QUIET    = 150;    // tail of the run with no idling
    localparam int DRAIN_CYC  = 4 * OPW + 40;

    localparam logic [OPW-1:0] MOST_NEG = {1'b1, {(OPW-1){1'b0}}};
    localparam logic [OPW-1:0] MOST_POS = {1'b0, {(OPW-1){1'b1}}};

    typedef enum int {
        MIX_FULL_RANDOM,
        MIX_SHARED_FACTOR,
        MIX_ONE_ZERO,
        MIX_SAME_MAGNITUDE,
        MIX_TINY,
        MIX_EXTREME_PAIR,
        MIX_MULTIPLE
    } operand_mix_t;

    class gcd_scoreboard;
        logic [OPW-1:0] expected_divisors[$];
        int failures;
        int checked;

        function logic [OPW-1:0] magnitude_of_operand(logic [OPW-1:0] raw);
            logic [OPW-1:0] v;
            v = raw;
            if (v[OPW-1])
                v = ~v + 1'b1;
            return v;
        endfunction

        function logic [OPW-1:0] euclid_gcd(logic [OPW-1:0] x, logic [OPW-1:0] y);
            logic [OPW-1:0] r;
            if (x == y)
                return x;
            if (x == '0)
                return y;
            if (y == '0)
                return x;
            while (1)
            begin
                r = x % y;
                if (r == '0)
                    return y;
                x = y;
                y = r;
            end
        endfunction

        function void note_operands(logic [OPW-1:0] a, logic [OPW-1:0] b);
            expected_divisors.push_back(
                euclid_gcd(magnitude_of_operand(a), magnitude_of_operand(b)));
        endfunction

        function void check_divisor(logic [OPW-1:0] actual);
            logic [OPW-1:0] want;
            checked++;
            if (expected_divisors.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected divisor, expected none, actual %0d",
                         $time, actual);
                return;
            end
            want = expected_divisors.pop_front();
            if (actual !== want)
            begin
                failures++;
                $display("%0t: divisor mismatch, expected %0d, actual %0d",
                         $time, want, actual);
            end
        endfunction

        function int pending();
            return expected_divisors.size();
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    logic [OPW-1:0] first_value;
    logic [OPW-1:0] second_value;
    logic           out_valid;
    logic           out_ready;
    logic [OPW-1:0] divisor;

    gcd_scoreboard board = new;
    bit            quiet_tail;
    bit            sender_bursty;
    int            sent_count;

    signed_gcd_unit #(
        .DATA_WIDTH(OPW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_value (first_value),
        .second_value(second_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .divisor     (divisor)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic logic [OPW-1:0] random_bits(int w);
        logic [OPW-1:0] mask;
        mask = (w <= 0) ? '0 : ({OPW{1'b1}} >> (OPW - w));
        return {$urandom, $urandom} & mask;
    endfunction

    // one transaction on the operand channel; called right after a falling edge
    task automatic send_operands(input logic [OPW-1:0] a, input logic [OPW-1:0] b);
        int gap;
        gap = 0;
        if (!quiet_tail && sender_bursty && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            in_valid     <= 1'b0;
            first_value  <= {$urandom, $urandom};
            second_value <= {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        first_value  <= a;
        second_value <= b;
        while (1)
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        board.note_operands(a, b);
        sent_count++;
        @(negedge clk);
    endtask

    // result channel: bursts of stall between runs of ready
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet_tail)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 300)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_divisor(divisor);
    end

    initial
    begin
        #20000000;
        $display("%0t: timeout with %0d results outstanding", $time, board.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        logic [OPW-1:0] g;
        int             gw;
        operand_mix_t   mix;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        first_value   = '0;
        second_value  = '0;
        quiet_tail    = 1'b0;
        sender_bursty = 1'b1;
        sent_count    = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners: zeros, most negative, equal magnitudes, powers of two
        send_operands('0, '0);
        send_operands('0, 64'd12345);
        send_operands(-64'sd987654321, '0);
        send_operands(MOST_NEG, MOST_NEG);
        send_operands(MOST_NEG, '0);
        send_operands('0, MOST_NEG);
        send_operands(MOST_NEG, MOST_POS);
        send_operands(MOST_POS, MOST_POS);
        send_operands(MOST_POS, MOST_POS - 1'b1);
        send_operands({OPW{1'b1}}, {OPW{1'b1}});
        send_operands(64'd1, {OPW{1'b1}});
        send_operands(MOST_NEG, 64'd6);
        send_operands(MOST_NEG, 64'sd1 <<< 62);
        send_operands(-64'sd12, 64'sd18);
        send_operands(64'sd5, -64'sd5);
        send_operands(MOST_POS, 64'd1);
        send_operands(64'd1 << 40, 64'd3 << 20);
        send_operands(64'd1 << 62, 64'd1 << 61);
        send_operands(64'd7540113804746346429, 64'd4660046610375530309);
        send_operands(-64'sd1000000007, -64'sd998244353);
        send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_operands(64'd2, 64'd3);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 64 == 0)
                sender_bursty = ($urandom_range(0, 3) != 0);
            if (i == N_RANDOM - N_QUIET)
                quiet_tail = 1'b1;
            mix = operand_mix_t'($urandom_range(0, 6));
            case (mix)
                MIX_FULL_RANDOM:
                begin
                    a = {$urandom, $urandom};
                    b = {$urandom, $urandom};
                end
                MIX_SHARED_FACTOR:
                begin
                    gw = $urandom_range(1, 32);
                    g  = random_bits(gw) << $urandom_range(0, 8);
                    a  = g * random_bits($urandom_range(1, OPW - 9 - gw));
                    b  = g * random_bits($urandom_range(1, OPW - 9 - gw));
                end
                MIX_ONE_ZERO:
                begin
                    a = random_bits($urandom_range(1, OPW));
                    b = '0;
                    if ($urandom_range(0, 1))
                    begin
                        b = a;
                        a = '0;
                    end
                end
                MIX_SAME_MAGNITUDE:
                begin
                    a = ($urandom_range(0, 7) == 0) ? MOST_NEG
                                                    : random_bits($urandom_range(1, OPW));
                    b = a;
                end
                MIX_TINY:
                begin
                    a = OPW'($urandom_range(0, 64));
                    b = OPW'($urandom_range(0, 64));
                end
                MIX_EXTREME_PAIR:
                begin
                    a = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
                    b = random_bits($urandom_range(1, 40)) << $urandom_range(0, 63);
                end
                default:
                begin
                    a = random_bits($urandom_range(1, OPW - 4));
                    b = a * OPW'($urandom_range(1, 9));
                end
            endcase
            if ($urandom_range(0, 1))
                a = -a;
            if ($urandom_range(0, 1))
                b = -b;
            send_operands(a, b);
        end

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Sent %0d operand pairs (directed corners plus random mixes),", sent_count);
        $display("checked %0d divisors, %0d failures.", board.checked, board.failures);
        if (board.failures == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sgcd_pkg.sv
sv/sgcd_seq.sv
sv/sgcd_dp.sv
sv/signed_gcd_unit.sv
bench/testbench.sv
